// File: hdl/fvnh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fvnh_pkg;

	// Number of octaves summed into one height
	localparam int OCTAVES = 4;

	// Fraction bits of a sample position
	localparam int FRAC_W = 16;

	// Sample position: 20-bit coordinate times the 13-bit base step, shifted by octave
	localparam int COORD_W = 20;
	localparam int POS_W = COORD_W + 13 + OCTAVES - 1;
	localparam logic signed [12:0] FREQ_BASE = 13'sd2621;

	// Lattice value (Q1.30) and smoothed value (Q.34)
	localparam int VAL_W = 32;
	localparam int NOISE_W = 36;

	// Octave sum and the top register
	localparam int TOTAL_W = NOISE_W + OCTAVES;
	localparam int SUM_FRAC = 34 + OCTAVES - 1;
	localparam int HEIGHT_W = 10;
	localparam logic [HEIGHT_W-1:0] PEAK_RST = HEIGHT_W'(64);

	// Lattice hash constants
	localparam logic [31:0] HASH_MUL_X = 32'd73856093;
	localparam logic [31:0] HASH_MUL_Z = 32'd19349663;
	localparam logic [31:0] HASH_MUL_A = 32'd15731;
	localparam logic [31:0] HASH_ADD_A = 32'd789221;
	localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
	localparam logic signed [VAL_W-1:0] VAL_BIAS = 32'sh40000000;

	// Stage loads inside one octave lane: stages 2 through 9
	localparam int OCT_STAGES = 8;
	typedef logic [OCT_STAGES-1:0] oct_en_t;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [NOISE_W-1:0] noise_t;

endpackage

`default_nettype wire

// File: hdl/fractal_value_noise_height.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                               Direction
// sample    sample_valid sample_stall world_x/z   in (stall driven out)
// result    height_valid height_stall height      out (stall driven in)
// config    cfg_valid cfg_ready cfg_data          in (ready driven out)
//
// Twelve register stages from sample to height; one sample per cycle while the output is not stalled.
// The hash multiplier chain sets the stage count.
// Reset clears the stage valid bits and loads the top height register with 64.
// Each stage holds while the next one is full and stalled; bubbles close up.

module fractal_value_noise_height import fvnh_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sample_valid,
	output logic                     sample_stall,
	input  wire logic [COORD_W-1:0]  world_x,
	input  wire logic [COORD_W-1:0]  world_z,
	output logic                     height_valid,
	input  wire logic                height_stall,
	output logic [HEIGHT_W-1:0]      height,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [HEIGHT_W-1:0] cfg_data
);

	localparam int NSTG = 12;
	localparam int PROD_W = TOTAL_W + 1 + HEIGHT_W + 1;
	localparam int HQ_W = PROD_W - SUM_FRAC - 1;

	logic [NSTG:1] vld_q;
	logic [NSTG+1:1] en;
	logic [HEIGHT_W-1:0] peak_q;

	pos_t px_s1 [OCTAVES];
	pos_t pz_s1 [OCTAVES];
	noise_t noise [OCTAVES];
	oct_en_t oct_en;

	logic signed [TOTAL_W-1:0] total_c, total_s10;
	logic signed [PROD_W-1:0] prod_s11;
	logic signed [HQ_W-1:0] hq;
	logic [HEIGHT_W-1:0] h_c, height_s12;

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		en[NSTG+1] = !height_stall;
		for (int i = NSTG; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign sample_stall = !en[1];
	assign oct_en = en[9:2];

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= sample_valid;
			for (int i = 2; i <= NSTG; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Hold the top height register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= PEAK_RST;
		end else if (cfg_valid) begin
			peak_q <= cfg_data;
		end
	end

	// Stage 1: sample positions per octave, and the octave lanes
	for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
		always_ff @(posedge clk) begin
			if (en[1]) begin
				px_s1[k] <= POS_W'($signed(world_x) * FREQ_BASE) <<< k;
				pz_s1[k] <= POS_W'($signed(world_z) * FREQ_BASE) <<< k;
			end
		end

		fvnh_octave u_octave (
			.clk   (clk),
			.en    (oct_en),
			.px_s1 (px_s1[k]),
			.pz_s1 (pz_s1[k]),
			.noise (noise[k])
		);
	end

	// Stage 10: weighted octave sum
	always_comb begin
		total_c = '0;
		for (int k = 0; k < OCTAVES; k++) begin
			total_c = total_c + (TOTAL_W'(noise[k]) <<< (OCTAVES - 1 - k));
		end
	end

	always_ff @(posedge clk) begin
		if (en[10]) total_s10 <= total_c;
	end

	// Stage 11: bias and scale by the top height
	always_ff @(posedge clk) begin
		if (en[11]) begin
			prod_s11 <= PROD_W'(((TOTAL_W+1)'(total_s10) + ((TOTAL_W+1)'(1) <<< SUM_FRAC))
				* $signed({1'b0, peak_q}));
		end
	end

	// Stage 12: drop fraction and clamp to 1..top height, or give 0 when the top height is 0
	assign hq = HQ_W'(prod_s11 >>> (SUM_FRAC + 1));

	always_comb begin
		if (peak_q == '0) begin
			h_c = '0;
		end else if (hq < HQ_W'(1)) begin
			h_c = HEIGHT_W'(1);
		end else if (hq > $signed({{(HQ_W-HEIGHT_W){1'b0}}, peak_q})) begin
			h_c = peak_q;
		end else begin
			h_c = HEIGHT_W'(hq);
		end
	end

	always_ff @(posedge clk) begin
		if (en[12]) height_s12 <= h_c;
	end

	assign height = height_s12;
	assign height_valid = vld_q[NSTG];

endmodule

`default_nettype wire

// File: hdl/fvnh_octave.sv
`timescale 1ns / 1ps
`default_nettype none

module fvnh_octave import fvnh_pkg::*; (
	input  wire logic    clk,
	input  wire oct_en_t en,
	input  wire pos_t    px_s1,
	input  wire pos_t    pz_s1,
	output noise_t       noise
);

	localparam int IDX_W = POS_W - FRAC_W;

	logic signed [IDX_W-1:0] ix, iz;
	logic [31:0] ux, uz;

	logic [31:0] hx_s2 [4];
	logic [31:0] hz_s2 [4];
	logic [FRAC_W-1:0] fx_s2, fz_s2;

	logic [31:0] n_s3 [4][4];
	logic [31:0] t_s3 [4][4];
	logic [FRAC_W-1:0] fx_s3, fz_s3;

	logic [31:0] n_s4 [4][4];
	logic [31:0] t_s4 [4][4];
	logic [FRAC_W-1:0] fx_s4, fz_s4;

	logic signed [VAL_W-1:0] v_s5 [4][4];
	logic [FRAC_W-1:0] fx_s5, fz_s5;

	logic signed [VAL_W+1:0] h_s6 [2][4];
	logic [FRAC_W-1:0] fx_s6, fz_s6;

	logic signed [NOISE_W-1:0] s_s7 [2][2];
	logic [FRAC_W-1:0] fx_s7, fz_s7;

	logic signed [NOISE_W-1:0] i1_s8, i2_s8;
	logic [FRAC_W-1:0] fz_s8;

	logic signed [NOISE_W-1:0] n_s9;

	logic signed [NOISE_W:0] d1, d2, d3;
	logic signed [NOISE_W+FRAC_W+1:0] p1, p2, p3;
	logic signed [NOISE_W+1:0] i1_c, i2_c, n_c;

	// Split positions into lattice cell and fraction
	assign ix = IDX_W'(px_s1 >>> FRAC_W);
	assign iz = IDX_W'(pz_s1 >>> FRAC_W);
	assign ux = 32'(ix);
	assign uz = 32'(iz);

	// Stage 2: per-coordinate hash products for offsets -1..2
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 4; i++) begin
				hx_s2[i] <= 32'((ux + 32'(i) - 32'd1) * HASH_MUL_X);
				hz_s2[i] <= 32'((uz + 32'(i) - 32'd1) * HASH_MUL_Z);
			end
			fx_s2 <= px_s1[FRAC_W-1:0];
			fz_s2 <= pz_s1[FRAC_W-1:0];
		end
	end

	// Stage 3: combine, mix and square
	always_ff @(posedge clk) begin
		logic [31:0] m0, m1;
		if (en[1]) begin
			for (int a = 0; a < 4; a++) begin
				for (int b = 0; b < 4; b++) begin
					m0 = hx_s2[a] ^ hz_s2[b];
					m1 = (m0 << 13) ^ m0;
					n_s3[a][b] <= m1;
					t_s3[a][b] <= 32'(m1 * m1);
				end
			end
			fx_s3 <= fx_s2;
			fz_s3 <= fz_s2;
		end
	end

	// Stage 4: scale and offset
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int a = 0; a < 4; a++) begin
				for (int b = 0; b < 4; b++) begin
					n_s4[a][b] <= n_s3[a][b];
					t_s4[a][b] <= 32'(t_s3[a][b] * HASH_MUL_A + HASH_ADD_A);
				end
			end
			fx_s4 <= fx_s3;
			fz_s4 <= fz_s3;
		end
	end

	// Stage 5: final product and map to signed lattice value
	always_ff @(posedge clk) begin
		logic [31:0] r;
		if (en[3]) begin
			for (int a = 0; a < 4; a++) begin
				for (int b = 0; b < 4; b++) begin
					r = 32'(n_s4[a][b] * t_s4[a][b] + HASH_ADD_B);
					v_s5[a][b] <= VAL_BIAS - $signed({1'b0, r[30:0]});
				end
			end
			fx_s5 <= fx_s4;
			fz_s5 <= fz_s4;
		end
	end

	// Stage 6: horizontal 1-2-1 pass
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int c = 0; c < 2; c++) begin
				for (int b = 0; b < 4; b++) begin
					h_s6[c][b] <= (VAL_W+2)'(v_s5[c][b]) + ((VAL_W+2)'(v_s5[c+1][b]) <<< 1)
						+ (VAL_W+2)'(v_s5[c+2][b]);
				end
			end
			fx_s6 <= fx_s5;
			fz_s6 <= fz_s5;
		end
	end

	// Stage 7: vertical 1-2-1 pass gives the four smoothed corners
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int c = 0; c < 2; c++) begin
				for (int r = 0; r < 2; r++) begin
					s_s7[c][r] <= NOISE_W'(h_s6[c][r]) + (NOISE_W'(h_s6[c][r+1]) <<< 1)
						+ NOISE_W'(h_s6[c][r+2]);
				end
			end
			fx_s7 <= fx_s6;
			fz_s7 <= fz_s6;
		end
	end

	// Stage 8: interpolate along x
	assign d1 = (NOISE_W+1)'(s_s7[1][0]) - (NOISE_W+1)'(s_s7[0][0]);
	assign d2 = (NOISE_W+1)'(s_s7[1][1]) - (NOISE_W+1)'(s_s7[0][1]);
	assign p1 = d1 * $signed({1'b0, fx_s7});
	assign p2 = d2 * $signed({1'b0, fx_s7});
	assign i1_c = (NOISE_W+2)'(s_s7[0][0]) + (NOISE_W+2)'(p1 >>> FRAC_W);
	assign i2_c = (NOISE_W+2)'(s_s7[0][1]) + (NOISE_W+2)'(p2 >>> FRAC_W);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			i1_s8 <= NOISE_W'(i1_c);
			i2_s8 <= NOISE_W'(i2_c);
			fz_s8 <= fz_s7;
		end
	end

	// Stage 9: interpolate along z
	assign d3 = (NOISE_W+1)'(i2_s8) - (NOISE_W+1)'(i1_s8);
	assign p3 = d3 * $signed({1'b0, fz_s8});
	assign n_c = (NOISE_W+2)'(i1_s8) + (NOISE_W+2)'(p3 >>> FRAC_W);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			n_s9 <= NOISE_W'(n_c);
		end
	end

	assign noise = n_s9;

endmodule

`default_nettype wire

// File: tb/tb_fractal_value_noise_height.sv
`timescale 1ns / 1ps

module tb_fractal_value_noise_height;
	import fvnh_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] z;
	} column_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [COORD_W-1:0] world_x = '0;
	logic [COORD_W-1:0] world_z = '0;
	logic height_valid;
	logic height_stall = 1'b0;
	logic [HEIGHT_W-1:0] height;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [HEIGHT_W-1:0] cfg_data = '0;

	column_t column_q[$];
	logic [HEIGHT_W-1:0] height_exp_q[$];
	logic [HEIGHT_W-1:0] top_height;
	int err_cnt = 0;
	int feed_wait = 0;
	int drain_wait = 0;
	int quiet_mode = 0;

	fractal_value_noise_height i_dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.world_x(world_x), .world_z(world_z),
		.height_valid(height_valid), .height_stall(height_stall), .height(height),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Q1.30 lattice hash value
	function automatic longint lattice_hash(input logic [31:0] lx, input logic [31:0] lz);
		logic [31:0] n;
		logic [31:0] t;
		n = (lx * HASH_MUL_X) ^ (lz * HASH_MUL_Z);
		n = (n << 13) ^ n;
		t = n * n;
		t = t * HASH_MUL_A + HASH_ADD_A;
		t = n * t + HASH_ADD_B;
		return longint'(32'h40000000) - longint'({1'b0, t[30:0]});
	endfunction

	// 3x3 smoothed lattice value, Q.34
	function automatic longint smooth_value(input logic [31:0] lx, input logic [31:0] lz);
		longint acc;
		acc = 0;
		for (int dx = -1; dx <= 1; dx++)
			for (int dz = -1; dz <= 1; dz++)
				acc += lattice_hash(lx + 32'(dx), lz + 32'(dz))
					<< ((dx == 0 ? 1 : 0) + (dz == 0 ? 1 : 0));
		return acc;
	endfunction

	// Bilinear value noise of one octave
	function automatic longint octave_value(input longint px, input longint pz);
		longint fx, fz, v1, v2, v3, v4, i1, i2;
		logic [31:0] ux, uz;
		fx = px & 64'hFFFF;
		fz = pz & 64'hFFFF;
		ux = 32'(px >>> FRAC_W);
		uz = 32'(pz >>> FRAC_W);
		v1 = smooth_value(ux, uz);
		v2 = smooth_value(ux + 1, uz);
		v3 = smooth_value(ux, uz + 1);
		v4 = smooth_value(ux + 1, uz + 1);
		i1 = v1 + (((v2 - v1) * fx) >>> FRAC_W);
		i2 = v3 + (((v4 - v3) * fx) >>> FRAC_W);
		return i1 + (((i2 - i1) * fz) >>> FRAC_W);
	endfunction

	function automatic logic [HEIGHT_W-1:0] column_height(input column_t c,
			input logic [HEIGHT_W-1:0] top);
		longint wx, wz, total, h;
		if (top == 0)
			return '0;
		wx = longint'(signed'(c.x));
		wz = longint'(signed'(c.z));
		total = 0;
		for (int k = 0; k < OCTAVES; k++)
			total += octave_value(wx * (2621 << k), wz * (2621 << k)) << (OCTAVES - 1 - k);
		h = ((total + (64'sd1 << SUM_FRAC)) * longint'(top)) / (64'sd1 << (SUM_FRAC + 1));
		if (h < 1)
			h = 1;
		if (h > longint'(top))
			h = top;
		return h[HEIGHT_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		err_cnt++;
	endtask

	function automatic int draw_wait();
		if (quiet_mode != 0)
			return 0;
		return $urandom_range(0, 10);
	endfunction

	// Drive requests from the pending queue
	always @(posedge clk) begin : drive
		int w;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				height_exp_q.insert(height_exp_q.size(),
					column_height({world_x, world_z}, top_height));
				w = draw_wait();
				if (column_q.size() > 0 && w == 0) begin
					world_x <= column_q[0].x;
					world_z <= column_q[0].z;
					void'(column_q.pop_front());
				end else begin
					sample_valid <= 1'b0;
					feed_wait <= (w > 0) ? w - 1 : 0;
				end
			end else if (!sample_valid) begin
				if (feed_wait > 0)
					feed_wait <= feed_wait - 1;
				else if (column_q.size() > 0) begin
					sample_valid <= 1'b1;
					world_x <= column_q[0].x;
					world_z <= column_q[0].z;
					void'(column_q.pop_front());
				end
			end
		end
	end

	// Check results and stall the output side
	always @(posedge clk) begin
		if (arst_n) begin
			if (height_valid && !height_stall) begin
				if (height_exp_q.size() == 0)
					report_mismatch($sformatf("unexpected height %0d", height));
				else begin
					if (height !== height_exp_q[0])
						report_mismatch($sformatf("height %0d, want %0d", height,
							height_exp_q[0]));
					void'(height_exp_q.pop_front());
				end
				drain_wait = draw_wait();
				height_stall <= (drain_wait != 0);
			end else if (height_stall) begin
				if (drain_wait > 0)
					drain_wait--;
				height_stall <= (drain_wait != 0);
			end
		end
	end

	task automatic write_top(input logic [HEIGHT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		top_height = val;
	endtask

	// Look between edges so that pending requests are seen settled
	task automatic wait_drained();
		while (column_q.size() > 0 || sample_valid || height_exp_q.size() > 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return {1'b1, 19'(0)};
			1: return {1'b0, {19{1'b1}}};
			2: return COORD_W'($urandom_range(0, 64)) - COORD_W'(32);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [HEIGHT_W-1:0] tops[6];
		logic [COORD_W-1:0] edges[6];
		tops = '{10'd1023, 10'd0, 10'd1, 10'd500, 10'd2, 10'd777};
		edges = '{20'h80000, 20'h7FFFF, 20'h0, 20'hFFFFF, 20'h1, 20'h55AAA};
		top_height = PEAK_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// Directed corners at the reset height
		foreach (edges[a])
			foreach (edges[b])
				if (a < 4 || b < 4)
					column_q.insert(column_q.size(), {edges[a], edges[b]});
		wait_drained();
		for (int p = 0; p < 8; p++) begin
			write_top(p < 6 ? tops[p] : 10'($urandom_range(0, 1023)));
			quiet_mode = (p == 3);
			for (int i = 0; i < 200; i++)
				column_q.insert(column_q.size(), {pick_coord(), pick_coord()});
			wait_drained();
		end
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
